// ----- rtl/core/spo2wr_pkg.sv -----
package spo2wr_pkg;

	// Sample and field widths.
	localparam int SAMPLE_BITS = 24;
	localparam int WIN_BITS    = 16;
	localparam int RATIO_BITS  = 16;
	localparam int LEVEL_BITS  = 15;

	// Datapath widths derived from the sample width.
	localparam int SUM_BITS   = SAMPLE_BITS + 1;
	localparam int MUL_BITS   = (SUM_BITS > RATIO_BITS) ? SUM_BITS : RATIO_BITS;
	localparam int PROD_BITS  = 2 * SAMPLE_BITS + 1;
	localparam int QUOT_BITS  = RATIO_BITS + 1;
	localparam int NUM_SHIFT  = 8;
	localparam int DIV_BITS   = PROD_BITS + QUOT_BITS - 1;
	localparam int STEP_BITS  = $clog2(QUOT_BITS);
	localparam int DROP_BITS  = 21;

	// SpO2 line in Q8.8: level = 110 - 25 * R, clamped to 0..100.
	localparam logic [DROP_BITS-1:0]  LEVEL_BASE = DROP_BITS'(28160);
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = LEVEL_BITS'(25600);
	localparam logic [MUL_BITS-1:0]   SLOPE      = MUL_BITS'(25);
	localparam logic [RATIO_BITS-1:0] RATIO_SAT  = {RATIO_BITS{1'b1}};
	localparam logic [WIN_BITS-1:0]   WINDOW_RESET = WIN_BITS'(100);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] red_sample;
		logic [SAMPLE_BITS-1:0] ir_sample;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] spo2_level;
		logic [RATIO_BITS-1:0] ratio_of_ratios;
		logic                  estimate_valid;
	} out_item_t;

	// Window extremes handed from the tracker to the ratio unit.
	typedef struct packed {
		logic                   closes;
		logic [SAMPLE_BITS-1:0] red_high;
		logic [SAMPLE_BITS-1:0] red_low;
		logic [SAMPLE_BITS-1:0] ir_high;
		logic [SAMPLE_BITS-1:0] ir_low;
	} window_t;

endpackage

// ----- rtl/core/spo2_window_ratio_estimator_core.sv -----
// SpO2 window ratio estimator. Each accepted item is one pair of filtered red
// and infrared samples. The block tracks each channel's minimum and maximum
// over a window of window_length pairs (a length of zero acts as one) and
// emits exactly one result item when the window closes, none otherwise. The
// result carries R = red_ac*(ir_max+ir_min)/((red_max+red_min)*ir_ac) in
// unsigned Q8.8, truncated and saturated at 65535, and SpO2 = 110 - 25*R in
// Q8.8 clamped to 0..100. If the window is flat on the infrared channel or a
// DC sum is zero, estimate_valid is low and the previous level and ratio are
// repeated. A pair that does not close a window does not occupy the ratio
// unit. A pair that closes one keeps the ratio unit busy, and no further
// pair is taken, while it passes through operand setup, two products on
// the shared multiplier, 17 restoring division steps on the shared
// compare-subtract stage, slope scaling, clamping and handoff. A window
// that yields no estimate skips the second product, the division, slope
// scaling and clamping and goes straight to the handoff. The handoff
// lasts longer while the output register still holds an item that has not
// been taken. While the unit is busy no item is taken; a finished result sits
// in the output register so the next window's pairs can flow in while it
// waits to be taken. Writing window_length is allowed only while the block is
// idle and does not restart the current window.
module spo2_window_ratio_estimator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  spo2wr_pkg::in_item_t             in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output spo2wr_pkg::out_item_t            out_data,
	input  logic                             cfg_we,
	input  logic [spo2wr_pkg::WIN_BITS-1:0]  cfg_data
);

	logic [spo2wr_pkg::WIN_BITS-1:0] window_length_q;
	logic                            in_fire;
	logic                            busy;
	logic                            res_valid;
	logic                            res_take;
	logic                            out_valid_q;
	spo2wr_pkg::out_item_t           out_data_q;
	spo2wr_pkg::out_item_t           res;
	spo2wr_pkg::window_t             win;

	// Items are taken only while the ratio unit is free.
	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;

	// A result moves into the output register when that register is empty or
	// is being emptied in this same cycle.
	assign res_take  = res_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The window length register; a write takes effect at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= spo2wr_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_length_q <= cfg_data;
		end
	end

	// Output register that decouples the result from the downstream stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
			out_data_q  <= res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	spo2wr_tracker u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (in_fire),
		.item          (in_data),
		.window_length (window_length_q),
		.win           (win)
	);

	spo2wr_ratio_unit u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_fire && win.closes),
		.win       (win),
		.take      (res_take),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

// ----- rtl/core/spo2wr_tracker.sv -----
// Tracks per-channel minimum and maximum and counts pairs within the window.
module spo2wr_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  spo2wr_pkg::in_item_t                item,
	input  logic [spo2wr_pkg::WIN_BITS-1:0]     window_length,
	output spo2wr_pkg::window_t                 win
);

	localparam int SB = spo2wr_pkg::SAMPLE_BITS;
	localparam int WB = spo2wr_pkg::WIN_BITS;

	logic [SB-1:0] red_low_q, red_high_q, ir_low_q, ir_high_q;
	logic [WB-1:0] count_q;
	logic [WB-1:0] count_next;

	always_comb begin
		count_next       = count_q + WB'(1);
		win.red_low      = (item.red_sample < red_low_q)  ? item.red_sample : red_low_q;
		win.red_high     = (item.red_sample > red_high_q) ? item.red_sample : red_high_q;
		win.ir_low       = (item.ir_sample < ir_low_q)    ? item.ir_sample  : ir_low_q;
		win.ir_high      = (item.ir_sample > ir_high_q)   ? item.ir_sample  : ir_high_q;
		// The window also closes when the pair count wraps to zero.
		win.closes       = (count_next == '0) || (count_next >= window_length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_low_q  <= '1;
			red_high_q <= '0;
			ir_low_q   <= '1;
			ir_high_q  <= '0;
			count_q    <= '0;
		end else if (fire) begin
			if (win.closes) begin
				red_low_q  <= '1;
				red_high_q <= '0;
				ir_low_q   <= '1;
				ir_high_q  <= '0;
				count_q    <= '0;
			end else begin
				red_low_q  <= win.red_low;
				red_high_q <= win.red_high;
				ir_low_q   <= win.ir_low;
				ir_high_q  <= win.ir_high;
				count_q    <= count_next;
			end
		end
	end

endmodule

// ----- rtl/core/spo2wr_ratio_unit.sv -----
// Sequencer around one shared multiplier and one compare-subtract stage that
// turns a closed window into the ratio of ratios and the SpO2 level.
module spo2wr_ratio_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  spo2wr_pkg::window_t   win,
	input  logic                  take,
	output logic                  busy,
	output logic                  res_valid,
	output spo2wr_pkg::out_item_t res
);

	localparam int SB = spo2wr_pkg::SAMPLE_BITS;
	localparam int SW = spo2wr_pkg::SUM_BITS;
	localparam int MW = spo2wr_pkg::MUL_BITS;
	localparam int DW = spo2wr_pkg::DIV_BITS;
	localparam int QW = spo2wr_pkg::QUOT_BITS;
	localparam int RW = spo2wr_pkg::RATIO_BITS;
	localparam int LW = spo2wr_pkg::LEVEL_BITS;
	localparam int TW = spo2wr_pkg::STEP_BITS;
	localparam int XW = spo2wr_pkg::DROP_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_NUM,
		ST_MUL_DEN,
		ST_DIVIDE,
		ST_SCALE,
		ST_CLAMP,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [SB-1:0]   red_high_q, red_low_q, ir_high_q, ir_low_q;
	logic [SB-1:0]   red_ac_q, ir_ac_q;
	logic [SW-1:0]   red_sum_q, ir_sum_q;
	logic [DW-1:0]   rem_q, den_q;
	logic [QW-1:0]   quot_q;
	logic [TW-1:0]   step_q;
	logic [XW-1:0]   drop_q;
	logic [RW-1:0]   last_ratio_q;
	logic [LW-1:0]   last_level_q;
	logic            last_valid_q;

	logic [MW-1:0]   mul_a, mul_b;
	logic [2*MW-1:0] prod;
	logic            ge;
	logic [RW-1:0]   ratio_sat;
	logic [XW-1:0]   diff;

	// Shared multiplier: numerator, denominator, then the slope scaling.
	always_comb begin
		ratio_sat = quot_q[QW-1] ? spo2wr_pkg::RATIO_SAT : quot_q[RW-1:0];
		case (state_q)
			ST_MUL_NUM: begin
				mul_a = MW'(red_ac_q);
				mul_b = MW'(ir_sum_q);
			end
			ST_MUL_DEN: begin
				mul_a = MW'(red_sum_q);
				mul_b = MW'(ir_ac_q);
			end
			ST_SCALE: begin
				mul_a = MW'(ratio_sat);
				mul_b = spo2wr_pkg::SLOPE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod      = {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, mul_b};
		ge        = (rem_q >= den_q);
		diff      = spo2wr_pkg::LEVEL_BASE - drop_q;
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res.spo2_level      = last_level_q;
	assign res.ratio_of_ratios = last_ratio_q;
	assign res.estimate_valid  = last_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			red_high_q   <= '0;
			red_low_q    <= '0;
			ir_high_q    <= '0;
			ir_low_q     <= '0;
			red_ac_q     <= '0;
			ir_ac_q      <= '0;
			red_sum_q    <= '0;
			ir_sum_q     <= '0;
			rem_q        <= '0;
			den_q        <= '0;
			quot_q       <= '0;
			step_q       <= '0;
			drop_q       <= '0;
			last_ratio_q <= '0;
			last_level_q <= '0;
			last_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						red_high_q <= win.red_high;
						red_low_q  <= win.red_low;
						ir_high_q  <= win.ir_high;
						ir_low_q   <= win.ir_low;
						state_q    <= ST_PREP;
					end
				end
				ST_PREP: begin
					red_ac_q  <= red_high_q - red_low_q;
					ir_ac_q   <= ir_high_q - ir_low_q;
					red_sum_q <= SW'(red_high_q) + SW'(red_low_q);
					ir_sum_q  <= SW'(ir_high_q) + SW'(ir_low_q);
					state_q   <= ST_MUL_NUM;
				end
				ST_MUL_NUM: begin
					// A flat infrared channel or a zero DC sum gives no estimate.
					if (ir_ac_q == '0 || ir_sum_q == '0 || red_sum_q == '0) begin
						last_valid_q <= 1'b0;
						state_q      <= ST_DONE;
					end else begin
						rem_q   <= DW'(prod) << spo2wr_pkg::NUM_SHIFT;
						state_q <= ST_MUL_DEN;
					end
				end
				ST_MUL_DEN: begin
					den_q   <= DW'(prod) << (QW - 1);
					quot_q  <= '0;
					step_q  <= TW'(QW - 1);
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (ge) begin
						rem_q <= rem_q - den_q;
					end
					quot_q <= {quot_q[QW-2:0], ge};
					den_q  <= den_q >> 1;
					step_q <= step_q - TW'(1);
					if (step_q == '0) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					drop_q  <= XW'(prod);
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (drop_q >= spo2wr_pkg::LEVEL_BASE) begin
						last_level_q <= '0;
					end else if (diff[LW-1:0] > spo2wr_pkg::LEVEL_MAX) begin
						last_level_q <= spo2wr_pkg::LEVEL_MAX;
					end else begin
						last_level_q <= diff[LW-1:0];
					end
					last_ratio_q <= ratio_sat;
					last_valid_q <= 1'b1;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
